[hw/rtl/tse_pkg.sv]
// Shared constants, codes and transfer payload types of the timer set expiry engine.
package tse_pkg;

  localparam int TIMER_SLOTS = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = $clog2(TIMER_SLOTS);
  localparam int RES_IDX_W   = $clog2(MAX_RESULTS);
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
  localparam int TIME_W      = 48;
  localparam int ID_W        = 32;
  localparam int IVL_W       = 32;

  typedef logic [1:0] op_t;
  localparam op_t OP_ADD   = 2'd0;
  localparam op_t OP_ERASE = 2'd1;
  localparam op_t OP_TICK  = 2'd2;

  typedef logic [1:0] status_t;
  localparam status_t ST_OK        = 2'd0;
  localparam status_t ST_FULL      = 2'd1;
  localparam status_t ST_NOT_FOUND = 2'd2;

  typedef struct packed {
    op_t               operation;
    logic [TIME_W-1:0] expiry_time;
    logic [IVL_W-1:0]  repeat_interval_ms;
    logic [ID_W-1:0]   cancel_id;
    logic [TIME_W-1:0] now_time;
  } in_item_t;

  typedef struct packed {
    status_t           status;
    logic [ID_W-1:0]   timer_id_out;
    logic              fired;
    logic              last;
    logic [TIME_W-1:0] next_expiry;
    logic              armed;
  } out_item_t;

endpackage

[hw/rtl/tse_if.sv]
// Valid/ready channel interfaces for the input and result transfers.
interface tse_in_if import tse_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface tse_out_if import tse_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[hw/rtl/timer_set_expiry_engine.sv]
// Timer table with add, erase and tick operations, built around one sequential slot scanner.
// The block takes one operation at a time and holds ready low until its last result transfer.
// Every pass walks the table one slot per cycle through a single slot index. An add or erase
// runs one lookup pass, then a pass that finds the earliest pending expiry, then one result
// transfer. A tick that fires k timers runs k + 1 lookup passes before that pass and emits
// max(k, 1) result transfers. Ready returns in the cycle after the last result transfer,
// and a stalled result transfer holds the block until it is taken. Up to MAX_RESULTS
// timers fire in one tick; due timers beyond that stay pending for a later tick.
module timer_set_expiry_engine import tse_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  tse_in_if.sink    in_ch,
  tse_out_if.source out_ch
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_SCAN  = 5'b00010,
    S_APPLY = 5'b00100,
    S_FIN   = 5'b01000,
    S_EMIT  = 5'b10000
  } state_t;

  state_t state;

  logic [TIMER_SLOTS-1:0] slot_valid;
  logic [TIMER_SLOTS-1:0] taken;
  logic [ID_W-1:0]        slot_timer_id [TIMER_SLOTS];
  logic [TIME_W-1:0]      slot_expiry   [TIMER_SLOTS];
  logic [IVL_W-1:0]       slot_interval [TIMER_SLOTS];
  logic [ID_W-1:0]        next_id;

  in_item_t              cmd;
  logic [SLOT_W-1:0]     idx;
  logic                  found;
  logic [SLOT_W-1:0]     hit;
  logic [TIME_W-1:0]     best_exp;
  logic [ID_W-1:0]       best_id;
  logic [IVL_W-1:0]      best_ivl;
  logic [CNT_W-1:0]      cnt;
  logic [RES_IDX_W-1:0]  emit_idx;
  logic [ID_W-1:0]       rbuf [MAX_RESULTS];
  status_t               res_status;
  logic                  res_fired;
  logic                  any;
  logic [TIME_W-1:0]     earliest;

  logic              cur_valid;
  logic [ID_W-1:0]   cur_id;
  logic [TIME_W-1:0] cur_exp;
  logic              cur_due;
  logic              cur_better;
  logic              scan_end;
  logic              emit_last;
  logic [TIME_W:0]   resched_sum;
  logic [TIME_W-1:0] resched;
  logic              in_fire;
  logic              out_fire;

  assign cur_valid  = slot_valid[idx];
  assign cur_id     = slot_timer_id[idx];
  assign cur_exp    = slot_expiry[idx];
  assign cur_due    = cur_valid && !taken[idx] && (cur_exp <= cmd.now_time);
  assign cur_better = !found || (cur_exp < best_exp) ||
                      ((cur_exp == best_exp) && (cur_id < best_id));
  assign scan_end   = (idx == SLOT_W'(TIMER_SLOTS - 1));
  assign emit_last  = ((CNT_W'(emit_idx) + CNT_W'(1)) == cnt);

  assign resched_sum = {1'b0, cmd.now_time} + (TIME_W + 1)'(best_ivl);
  assign resched     = resched_sum[TIME_W] ? {TIME_W{1'b1}} : resched_sum[TIME_W-1:0];

  assign in_ch.ready  = (state == S_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = (state == S_EMIT);
  assign out_fire     = out_ch.valid && out_ch.ready;

  assign out_ch.data.status       = res_status;
  assign out_ch.data.timer_id_out = rbuf[emit_idx];
  assign out_ch.data.fired        = res_fired;
  assign out_ch.data.last         = emit_last;
  assign out_ch.data.next_expiry  = earliest;
  assign out_ch.data.armed        = any;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      taken      <= '0;
      next_id    <= ID_W'(1);
      idx        <= '0;
      found      <= 1'b0;
      cnt        <= '0;
      emit_idx   <= '0;
      any        <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_SCAN;
            idx   <= '0;
            found <= 1'b0;
            taken <= '0;
            cnt   <= '0;
          end
        end
        S_SCAN: begin
          unique case (cmd.operation)
            OP_ADD: begin
              if (!found && !cur_valid) begin
                found <= 1'b1;
              end
            end
            OP_ERASE: begin
              if (!found && cur_valid && (cur_id == cmd.cancel_id)) begin
                found <= 1'b1;
              end
            end
            OP_TICK: begin
              if (cur_due && cur_better) begin
                found <= 1'b1;
              end
            end
            default: begin
            end
          endcase
          if (scan_end) begin
            state <= S_APPLY;
          end
          idx <= idx + SLOT_W'(1);
        end
        S_APPLY: begin
          idx <= '0;
          any <= 1'b0;
          unique case (cmd.operation)
            OP_ADD: begin
              if (found) begin
                slot_valid[hit] <= 1'b1;
                next_id         <= next_id + ID_W'(1);
              end
              cnt   <= CNT_W'(1);
              state <= S_FIN;
            end
            OP_ERASE: begin
              if (found) begin
                slot_valid[hit] <= 1'b0;
              end
              cnt   <= CNT_W'(1);
              state <= S_FIN;
            end
            OP_TICK: begin
              if (found && (cnt < CNT_W'(MAX_RESULTS))) begin
                taken[hit] <= 1'b1;
                if (best_ivl == '0) begin
                  slot_valid[hit] <= 1'b0;
                end
                cnt   <= cnt + CNT_W'(1);
                found <= 1'b0;
                state <= S_SCAN;
              end else begin
                if (cnt == '0) begin
                  cnt <= CNT_W'(1);
                end
                state <= S_FIN;
              end
            end
            default: begin
              cnt   <= CNT_W'(1);
              state <= S_FIN;
            end
          endcase
        end
        S_FIN: begin
          if (slot_valid[idx] && (!any || (slot_expiry[idx] < earliest))) begin
            any <= 1'b1;
          end
          if (scan_end) begin
            state    <= S_EMIT;
            emit_idx <= '0;
          end
          idx <= idx + SLOT_W'(1);
        end
        S_EMIT: begin
          if (out_fire) begin
            if (emit_last) begin
              state <= S_IDLE;
            end else begin
              emit_idx <= emit_idx + RES_IDX_W'(1);
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd        <= in_ch.data;
      res_status <= ST_OK;
      res_fired  <= 1'b0;
    end
    if (state == S_SCAN) begin
      unique case (cmd.operation)
        OP_ADD: begin
          if (!found && !cur_valid) begin
            hit <= idx;
          end
        end
        OP_ERASE: begin
          if (!found && cur_valid && (cur_id == cmd.cancel_id)) begin
            hit <= idx;
          end
        end
        OP_TICK: begin
          if (cur_due && cur_better) begin
            hit      <= idx;
            best_exp <= cur_exp;
            best_id  <= cur_id;
            best_ivl <= slot_interval[idx];
          end
        end
        default: begin
        end
      endcase
    end
    if (state == S_APPLY) begin
      earliest <= '0;
      unique case (cmd.operation)
        OP_ADD: begin
          if (found) begin
            slot_timer_id[hit] <= next_id;
            slot_expiry[hit]   <= cmd.expiry_time;
            slot_interval[hit] <= cmd.repeat_interval_ms;
            rbuf[0]            <= next_id;
          end else begin
            rbuf[0]    <= '0;
            res_status <= ST_FULL;
          end
        end
        OP_ERASE: begin
          rbuf[0] <= '0;
          if (!found) begin
            res_status <= ST_NOT_FOUND;
          end
        end
        OP_TICK: begin
          if (found && (cnt < CNT_W'(MAX_RESULTS))) begin
            rbuf[cnt[RES_IDX_W-1:0]] <= best_id;
            slot_expiry[hit]         <= resched;
            res_fired                <= 1'b1;
          end else if (cnt == '0) begin
            rbuf[0] <= '0;
          end
        end
        default: begin
          rbuf[0] <= '0;
        end
      endcase
    end
    if (state == S_FIN) begin
      if (slot_valid[idx] && (!any || (slot_expiry[idx] < earliest))) begin
        earliest <= slot_expiry[idx];
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> !out_ch.valid)
    else $error("input taken while results are pending");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (cnt != '0) && (cnt <= CNT_W'(MAX_RESULTS)))
    else $error("result count out of range");

  a_armed_match: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> (out_ch.data.armed == (|slot_valid)))
    else $error("armed flag disagrees with the table");

  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.fired |-> (out_ch.data.status == ST_OK))
    else $error("fired result with error status");

  a_id_advance: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && (next_id != $past(next_id)) |->
      $past(state == S_APPLY) && $past(cmd.operation == OP_ADD))
    else $error("id counter moved outside an add");

endmodule

[sim/timer_set_expiry_checker.sv]
// Checker that predicts the timer engine's result transfers and compares them as they arrive.
`timescale 1ns / 100ps

module timer_set_expiry_checker import tse_pkg::*; (
  input  logic clk,
  input  logic rst,
  tse_in_if    in_ch,
  tse_out_if   out_ch,
  output int   mismatch_count,
  output int   results_owed
);

  localparam int OWED_DEPTH = 64;
  localparam int OWED_PTR_W = $clog2(OWED_DEPTH);

  bit                tbl_valid    [TIMER_SLOTS];
  logic [ID_W-1:0]   tbl_id       [TIMER_SLOTS];
  logic [TIME_W-1:0] tbl_expiry   [TIMER_SLOTS];
  logic [IVL_W-1:0]  tbl_interval [TIMER_SLOTS];
  logic [ID_W-1:0]   id_counter;

  out_item_t             owed_buf [OWED_DEPTH];
  logic [OWED_PTR_W-1:0] owed_wr   = '0;
  logic [OWED_PTR_W-1:0] owed_rd   = '0;
  int                    errors    = 0;
  int                    owed_size = 0;

  assign mismatch_count = errors;
  assign results_owed   = owed_size;

  function automatic void compare_field(string field, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      errors++;
    end
  endfunction

  task automatic predict_results(input in_item_t op_in);
    int                free_slot;
    int                hit;
    int                best;
    int                slot;
    int                fire_cnt;
    bit                taken      [TIMER_SLOTS];
    int                fire_order [MAX_RESULTS];
    logic [TIME_W:0]   bumped;
    bit                any_pending;
    logic [TIME_W-1:0] earliest;
    out_item_t         res [MAX_RESULTS];
    int                res_cnt;
    out_item_t         r;
    free_slot   = -1;
    hit         = -1;
    fire_cnt    = 0;
    res_cnt     = 0;
    any_pending = 1'b0;
    earliest    = '0;
    r           = '0;
    case (op_in.operation)
      OP_ADD: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (!tbl_valid[i] && free_slot < 0) free_slot = i;
        end
        if (free_slot < 0) begin
          r.status = ST_FULL;
        end else begin
          tbl_valid[free_slot]    = 1'b1;
          tbl_id[free_slot]       = id_counter;
          tbl_expiry[free_slot]   = op_in.expiry_time;
          tbl_interval[free_slot] = op_in.repeat_interval_ms;
          r.timer_id_out          = id_counter;
          id_counter              = id_counter + ID_W'(1);
        end
        res[res_cnt] = r;
        res_cnt++;
      end
      OP_ERASE: begin
        for (int i = 0; i < TIMER_SLOTS; i++) begin
          if (tbl_valid[i] && tbl_id[i] == op_in.cancel_id && hit < 0) hit = i;
        end
        if (hit < 0) r.status = ST_NOT_FOUND;
        else tbl_valid[hit] = 1'b0;
        res[res_cnt] = r;
        res_cnt++;
      end
      OP_TICK: begin
        for (int i = 0; i < TIMER_SLOTS; i++) taken[i] = 1'b0;
        for (int n = 0; n < MAX_RESULTS; n++) begin
          best = -1;
          for (int i = 0; i < TIMER_SLOTS; i++) begin
            if (tbl_valid[i] && !taken[i] && tbl_expiry[i] <= op_in.now_time) begin
              if (best < 0 || tbl_expiry[i] < tbl_expiry[best] ||
                  (tbl_expiry[i] == tbl_expiry[best] && tbl_id[i] < tbl_id[best]))
                best = i;
            end
          end
          if (best < 0) break;
          taken[best]          = 1'b1;
          fire_order[fire_cnt] = best;
          fire_cnt++;
        end
        for (int k = 0; k < fire_cnt; k++) begin
          slot           = fire_order[k];
          r              = '0;
          r.fired        = 1'b1;
          r.timer_id_out = tbl_id[slot];
          res[res_cnt]   = r;
          res_cnt++;
          if (tbl_interval[slot] == '0) begin
            tbl_valid[slot] = 1'b0;
          end else begin
            bumped           = {1'b0, op_in.now_time} + (TIME_W + 1)'(tbl_interval[slot]);
            tbl_expiry[slot] = bumped[TIME_W] ? '1 : bumped[TIME_W-1:0];
          end
        end
        if (fire_cnt == 0) begin
          res[res_cnt] = r;
          res_cnt++;
        end
      end
      default: begin
        res[res_cnt] = r;
        res_cnt++;
      end
    endcase
    for (int i = 0; i < TIMER_SLOTS; i++) begin
      if (tbl_valid[i] && (!any_pending || tbl_expiry[i] < earliest)) begin
        earliest    = tbl_expiry[i];
        any_pending = 1'b1;
      end
    end
    for (int k = 0; k < res_cnt; k++) begin
      r                 = res[k];
      r.last            = (k == res_cnt - 1);
      r.next_expiry     = any_pending ? earliest : '0;
      r.armed           = any_pending;
      owed_buf[owed_wr] = r;
      owed_wr           = owed_wr + OWED_PTR_W'(1);
      owed_size++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (rst) begin
      owed_wr   = '0;
      owed_rd   = '0;
      owed_size = 0;
      for (int i = 0; i < TIMER_SLOTS; i++) tbl_valid[i] = 1'b0;
      id_counter = ID_W'(1);
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (owed_size == 0) begin
          $error("Result transfer arrived with no result owed.");
          errors++;
        end else begin
          want    = owed_buf[owed_rd];
          owed_rd = owed_rd + OWED_PTR_W'(1);
          owed_size--;
          compare_field("status", 64'(want.status), 64'(out_ch.data.status));
          compare_field("timer_id_out", 64'(want.timer_id_out),
                        64'(out_ch.data.timer_id_out));
          compare_field("fired", 64'(want.fired), 64'(out_ch.data.fired));
          compare_field("last", 64'(want.last), 64'(out_ch.data.last));
          compare_field("next_expiry", 64'(want.next_expiry),
                        64'(out_ch.data.next_expiry));
          compare_field("armed", 64'(want.armed), 64'(out_ch.data.armed));
        end
      end
      if (in_ch.valid && in_ch.ready) predict_results(in_ch.data);
    end
  end

endmodule

[sim/timer_set_expiry_engine_tb.sv]
// Testbench top that drives the timer engine's operations and reports the checker's verdict.
`timescale 1ns / 100ps

module timer_set_expiry_engine_tb;
  import tse_pkg::*;

  localparam op_t         OP_UNUSED    = 2'd3;
  localparam int          RANDOM_ITEMS = 72;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tse_in_if  in_ch ();
  tse_out_if out_ch ();

  int                mismatch_count;
  int                results_owed;
  bit                steady     = 1'b0;
  int                hold_left  = 0;
  int                ids_issued = 0;
  int unsigned       cycle_count = 0;
  logic [TIME_W-1:0] clock_now;

  timer_set_expiry_engine dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  timer_set_expiry_checker expiry_check (
    .clk            (clk),
    .rst            (rst),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .results_owed   (results_owed)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  function automatic int idle_len();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [TIME_W-1:0] random_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  function automatic in_item_t random_fields(op_t op);
    in_item_t item;
    item.operation          = op;
    item.expiry_time        = random_time();
    item.repeat_interval_ms = $urandom;
    item.cancel_id          = $urandom;
    item.now_time           = random_time();
    return item;
  endfunction

  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 2) == 0) begin
        hold_left = idle_len();
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_item(input in_item_t item);
    int gap;
    gap = steady ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= item;
    if (item.operation == OP_ADD) ids_issued++;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    wait (results_owed == 0);
  endtask

  task automatic send_add(input logic [TIME_W-1:0] expiry, input logic [IVL_W-1:0] period);
    in_item_t item;
    item                    = random_fields(OP_ADD);
    item.expiry_time        = expiry;
    item.repeat_interval_ms = period;
    send_item(item);
  endtask

  task automatic send_erase(input logic [ID_W-1:0] id);
    in_item_t item;
    item           = random_fields(OP_ERASE);
    item.cancel_id = id;
    send_item(item);
  endtask

  task automatic send_tick(input logic [TIME_W-1:0] now);
    in_item_t item;
    item          = random_fields(OP_TICK);
    item.now_time = now;
    send_item(item);
  endtask

  initial begin
    in_item_t item;
    int       roll;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_tick('0);
    send_erase('1);
    send_add('0, '0);
    send_add('1, '1);
    send_add(48'd100, 32'd7);
    send_add(48'd100, '0);
    send_tick(48'd100);
    send_erase(32'd2);
    send_erase(32'd2);
    send_item(random_fields(OP_UNUSED));
    for (int k = 0; k < 15; k++) begin
      send_add(TIME_W'((k / 2) * 10), (k == 1) ? '1 : (k % 3 == 0) ? '0 : IVL_W'(k * 5));
    end
    send_add(48'd5, 32'd1);
    send_tick('1);
    send_tick('1);
    drain_results();

    clock_now = 48'd200;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      steady = (n >= 40 && n < 60);
      roll   = $urandom_range(0, 99);
      if (roll < 45) begin
        item = random_fields(OP_ADD);
        if ($urandom_range(0, 99) < 75) item.expiry_time = clock_now + $urandom_range(0, 300);
        roll = $urandom_range(0, 99);
        if (roll < 40) item.repeat_interval_ms = '0;
        else if (roll < 90) item.repeat_interval_ms = $urandom_range(1, 150);
      end else if (roll < 65) begin
        item = random_fields(OP_ERASE);
        if ($urandom_range(0, 99) < 75) item.cancel_id = $urandom_range(1, ids_issued + 1);
      end else if (roll < 96) begin
        item      = random_fields(OP_TICK);
        clock_now = clock_now + $urandom_range(0, 120);
        if ($urandom_range(0, 99) >= 5) item.now_time = clock_now;
      end else begin
        item = random_fields(OP_UNUSED);
      end
      if ($urandom_range(0, 19) == 0) drain_results();
      send_item(item);
    end
    steady = 1'b0;

    drain_results();
    repeat (50) @(posedge clk);
    if (mismatch_count == 0 && results_owed == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
